// ===== hw/rtl/fse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_pkg
// Types, constants and helper functions of the per-flow statistics engine.
// ----------------------------------------------------------------------------
package fse_pkg;

   localparam int FLOWS   = 256;
   localparam int SLOT_W  = 8;
   localparam int LEN_W   = 17;
   localparam int LBINS   = 6;
   localparam int TBINS   = 10;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [4:0] SEL_PKT_CNT    = 5'd0;
   localparam logic [4:0] SEL_BYTE_CNT   = 5'd1;
   localparam logic [4:0] SEL_FIRST_TIME = 5'd2;
   localparam logic [4:0] SEL_LAST_TIME  = 5'd3;
   localparam logic [4:0] SEL_GAP_SUM    = 5'd4;
   localparam logic [4:0] SEL_LEN_MIN    = 5'd5;
   localparam logic [4:0] SEL_LEN_MAX    = 5'd6;
   localparam logic [4:0] SEL_TTL_MIN    = 5'd7;
   localparam logic [4:0] SEL_TTL_MAX    = 5'd8;
   localparam logic [4:0] SEL_FLAGS      = 5'd9;
   localparam logic [4:0] SEL_WIN_MIN    = 5'd10;
   localparam logic [4:0] SEL_WIN_MAX    = 5'd11;
   localparam logic [4:0] SEL_EXP_SEQ    = 5'd12;
   localparam logic [4:0] SEL_LAST_IDENT = 5'd13;
   localparam logic [4:0] SEL_RETX_PKTS  = 5'd14;
   localparam logic [4:0] SEL_RETX_BYTES = 5'd15;
   localparam logic [4:0] SEL_LEN_BIN0   = 5'd16;
   localparam logic [4:0] SEL_TTL_BIN0   = 5'd22;

   localparam logic [LEN_W-1:0] LEN_MIN_INIT = 17'h0ffff;
   localparam logic [7:0]       TTL_MIN_INIT = 8'hff;
   localparam logic [15:0]      WIN_MIN_INIT = 16'hffff;

   typedef struct packed {
      logic [31:0]             pkt_cnt;
      logic [63:0]             byte_cnt;
      logic [63:0]             first_time;
      logic [63:0]             last_time;
      logic [63:0]             gap_sum;
      logic [LEN_W-1:0]        len_min;
      logic [LEN_W-1:0]        len_max;
      logic [7:0]              ttl_min;
      logic [7:0]              ttl_max;
      logic [7:0]              flags;
      logic [15:0]             win_min;
      logic [15:0]             win_max;
      logic [31:0]             exp_seq;
      logic [15:0]             last_ident;
      logic [31:0]             retx_pkts;
      logic [31:0]             retx_bytes;
      logic [LBINS-1:0][31:0]  len_bins;
      logic [TBINS-1:0][31:0]  ttl_bins;
   } fse_rec_type;

   localparam int REC_W = $bits(fse_rec_type);

   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] flow_slot;
      logic [4:0]        stat_select;
      logic [63:0]       timestamp;
      logic [LEN_W-1:0]  ip_length;
      logic [7:0]        hop_ttl;
      logic [1:0]        tcp_mode;
      logic [7:0]        tcp_flag_bits;
      logic [15:0]       tcp_window;
      logic [31:0]       tcp_sequence;
      logic [15:0]       ip_ident;
      logic [15:0]       segment_length;
   } fse_req_type;

   function automatic fse_rec_type fse_init_rec();
      fse_rec_type r;
      r         = '0;
      r.len_min = LEN_MIN_INIT;
      r.ttl_min = TTL_MIN_INIT;
      r.win_min = WIN_MIN_INIT;
      return r;
   endfunction

   function automatic logic [2:0] fse_len_bin(input logic [LEN_W-1:0] len);
      logic [2:0] b;
      if (len <= 17'd127)       b = 3'd0;
      else if (len <= 17'd255)  b = 3'd1;
      else if (len <= 17'd511)  b = 3'd2;
      else if (len <= 17'd1023) b = 3'd3;
      else if (len <= 17'd1513) b = 3'd4;
      else                      b = 3'd5;
      return b;
   endfunction

   function automatic logic [3:0] fse_ttl_bin(input logic [7:0] ttl);
      logic [3:0] b;
      logic [7:0] off;
      off = ttl - 8'd65;
      if (ttl <= 8'd1)       b = 4'd0;
      else if (ttl <= 8'd5)  b = 4'd1;
      else if (ttl <= 8'd32) b = 4'd2;
      else if (ttl <= 8'd64) b = 4'd3;
      else                   b = 4'd4 + {1'b0, off[7:5]};
      return b;
   endfunction

   function automatic logic [63:0] fse_read_word(input fse_rec_type r, input logic [4:0] sel);
      logic [63:0] w;
      logic [4:0]  li;
      logic [4:0]  ti;
      li = sel - SEL_LEN_BIN0;
      ti = sel - SEL_TTL_BIN0;
      priority if (sel == SEL_PKT_CNT)    w = {32'd0, r.pkt_cnt};
      else if (sel == SEL_BYTE_CNT)       w = r.byte_cnt;
      else if (sel == SEL_FIRST_TIME)     w = r.first_time;
      else if (sel == SEL_LAST_TIME)      w = r.last_time;
      else if (sel == SEL_GAP_SUM)        w = r.gap_sum;
      else if (sel == SEL_LEN_MIN)        w = {47'd0, r.len_min};
      else if (sel == SEL_LEN_MAX)        w = {47'd0, r.len_max};
      else if (sel == SEL_TTL_MIN)        w = {56'd0, r.ttl_min};
      else if (sel == SEL_TTL_MAX)        w = {56'd0, r.ttl_max};
      else if (sel == SEL_FLAGS)          w = {56'd0, r.flags};
      else if (sel == SEL_WIN_MIN)        w = {48'd0, r.win_min};
      else if (sel == SEL_WIN_MAX)        w = {48'd0, r.win_max};
      else if (sel == SEL_EXP_SEQ)        w = {32'd0, r.exp_seq};
      else if (sel == SEL_LAST_IDENT)     w = {48'd0, r.last_ident};
      else if (sel == SEL_RETX_PKTS)      w = {32'd0, r.retx_pkts};
      else if (sel == SEL_RETX_BYTES)     w = {32'd0, r.retx_bytes};
      else if (sel < SEL_TTL_BIN0)        w = {32'd0, r.len_bins[li[2:0]]};
      else                                w = {32'd0, r.ttl_bins[ti[3:0]]};
      return w;
   endfunction

endpackage

// ===== hw/rtl/fse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fse_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_update
// Record update datapath: counters, times, extremes, histograms, TCP state.
// ----------------------------------------------------------------------------
module fse_update (
   input  fse_pkg::fse_rec_type rec,
   input  fse_pkg::fse_req_type req,
   input  logic [63:0]          delta,
   input  logic [2:0]           len_bin,
   input  logic [3:0]           ttl_bin,
   output fse_pkg::fse_rec_type rec_out,
   output logic                 retx
);
   import fse_pkg::*;

   logic seq_below;

   assign seq_below = req.tcp_sequence < rec.exp_seq;

   always_comb begin
      rec_out = rec;
      retx    = 1'b0;
      rec_out.pkt_cnt = rec.pkt_cnt + 32'd1;
      if (rec.first_time == 64'd0) begin
         rec_out.first_time = req.timestamp;
         rec_out.gap_sum    = 64'd0;
      end else begin
         rec_out.gap_sum = rec.gap_sum + delta;
      end
      rec_out.last_time = req.timestamp;
      rec_out.byte_cnt  = rec.byte_cnt + {47'd0, req.ip_length};
      if (req.ip_length < rec.len_min) rec_out.len_min = req.ip_length;
      if (req.ip_length > rec.len_max) rec_out.len_max = req.ip_length;
      if (req.hop_ttl < rec.ttl_min) rec_out.ttl_min = req.hop_ttl;
      if (req.hop_ttl > rec.ttl_max) rec_out.ttl_max = req.hop_ttl;
      rec_out.len_bins[len_bin] = rec.len_bins[len_bin] + 32'd1;
      rec_out.ttl_bins[ttl_bin] = rec.ttl_bins[ttl_bin] + 32'd1;
      if (req.tcp_mode != 2'd0) begin
         rec_out.flags = rec.flags | req.tcp_flag_bits;
         if (req.tcp_window < rec.win_min) rec_out.win_min = req.tcp_window;
         if (req.tcp_window > rec.win_max) rec_out.win_max = req.tcp_window;
      end
      if (req.tcp_mode[1]) begin
         if (req.segment_length != 16'd0 && seq_below && req.ip_ident != rec.last_ident) begin
            rec_out.retx_pkts  = rec.retx_pkts + 32'd1;
            rec_out.retx_bytes = rec.retx_bytes + {16'd0, req.segment_length};
            retx               = 1'b1;
         end else begin
            rec_out.exp_seq    = req.tcp_sequence + {16'd0, req.segment_length};
            rec_out.last_ident = req.ip_ident;
         end
      end
   end

endmodule

// ===== hw/rtl/per_flow_statistics_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_statistics_engine
// Per-flow statistics table: one record per slot in a wide RAM, updated by
// read-modify-write, or read out one statistic word at a time.
//
//   channel | direction | handshake           | beat
//   req_    | in        | start & !busy       | one update or read command
//   rsp_    | out       | rsp_strobe, 1 cycle | one result word and flags
//
// Each command passes through RAM read, prepare (gap, bin index) and commit
// (write back, register result). Commands never overlap: a new command is
// only taken once busy has dropped after the commit of the one before.
// The result strobe is registered in commit and is high in the cycle in
// which busy drops; the next command is taken at the edge that ends it.
// Reset clears the slot valid bits at once; no clearing pass.
// The receiver cannot stall; busy is high during reset.
// ----------------------------------------------------------------------------
module per_flow_statistics_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_opcode,
   input  logic [fse_pkg::SLOT_W-1:0] req_flow_slot,
   input  logic [4:0]                req_stat_select,
   input  logic [63:0]               req_timestamp,
   input  logic [16:0]               req_ip_length,
   input  logic [7:0]                req_hop_ttl,
   input  logic [1:0]                req_tcp_mode,
   input  logic [7:0]                req_tcp_flag_bits,
   input  logic [15:0]               req_tcp_window,
   input  logic [31:0]               req_tcp_sequence,
   input  logic [15:0]               req_ip_ident,
   input  logic [15:0]               req_segment_length,
   output logic                      rsp_strobe,
   output logic [63:0]               rsp_read_data,
   output logic                      rsp_retransmit_seen,
   output logic                      rsp_flow_was_new
);
   import fse_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PREP   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              accept;
   fse_req_type       req_ff;
   logic [FLOWS-1:0]  valid_ff, valid_in;
   logic [REC_W-1:0]  rd_data;
   fse_rec_type       rd_rec;
   fse_rec_type       rec_ff;
   logic              valid_hit_ff;
   logic [63:0]       delta_ff;
   logic [2:0]        len_bin_ff;
   logic [3:0]        ttl_bin_ff;
   fse_rec_type       new_rec;
   logic              retx;
   logic              wr_en;
   logic              rsp_strobe_ff;
   logic [63:0]       rsp_data_ff;
   logic              rsp_retx_ff;
   logic              rsp_new_ff;

   assign busy   = reset || (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign rd_rec = fse_rec_type'(rd_data);
   assign wr_en  = (state_ff == ST_COMMIT) && (req_ff.opcode == OP_UPDATE);

   fse_ram #(
      .WIDTH (REC_W),
      .DEPTH (FLOWS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_ff.flow_slot),
      .wr_data (new_rec),
      .rd_en   (accept),
      .rd_addr (req_flow_slot),
      .rd_data (rd_data)
   );

   fse_update u_update (
      .rec     (rec_ff),
      .req     (req_ff),
      .delta   (delta_ff),
      .len_bin (len_bin_ff),
      .ttl_bin (ttl_bin_ff),
      .rec_out (new_rec),
      .retx    (retx)
   );

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_PREP;
         ST_PREP:   state_in = ST_COMMIT;
         ST_COMMIT: begin
            state_in = ST_IDLE;
            if (req_ff.opcode == OP_UPDATE) valid_in[req_ff.flow_slot] = 1'b1;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= (state_ff == ST_COMMIT);
      end
   end

   // hold the command, prepare the record, then register the result
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.opcode         <= req_opcode;
         req_ff.flow_slot      <= req_flow_slot;
         req_ff.stat_select    <= req_stat_select;
         req_ff.timestamp      <= req_timestamp;
         req_ff.ip_length      <= req_ip_length;
         req_ff.hop_ttl        <= req_hop_ttl;
         req_ff.tcp_mode       <= req_tcp_mode;
         req_ff.tcp_flag_bits  <= req_tcp_flag_bits;
         req_ff.tcp_window     <= req_tcp_window;
         req_ff.tcp_sequence   <= req_tcp_sequence;
         req_ff.ip_ident       <= req_ip_ident;
         req_ff.segment_length <= req_segment_length;
      end
      if (state_ff == ST_PREP) begin
         valid_hit_ff <= valid_ff[req_ff.flow_slot];
         len_bin_ff   <= fse_len_bin(req_ff.ip_length);
         ttl_bin_ff   <= fse_ttl_bin(req_ff.hop_ttl);
         if (valid_ff[req_ff.flow_slot]) begin
            rec_ff   <= rd_rec;
            delta_ff <= req_ff.timestamp - rd_rec.last_time;
         end else begin
            rec_ff   <= fse_init_rec();
            delta_ff <= req_ff.timestamp;
         end
      end
      if (state_ff == ST_COMMIT) begin
         if (req_ff.opcode == OP_READ) begin
            rsp_data_ff <= valid_hit_ff ? fse_read_word(rec_ff, req_ff.stat_select) : 64'd0;
            rsp_retx_ff <= 1'b0;
            rsp_new_ff  <= 1'b0;
         end else begin
            rsp_data_ff <= 64'd0;
            rsp_retx_ff <= retx;
            rsp_new_ff  <= !valid_hit_ff;
         end
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_retransmit_seen = rsp_retx_ff;
   assign rsp_flow_was_new    = rsp_new_ff;

endmodule

// ===== hw/rtl/fse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_checker
// Port-level timing checks of the per-flow statistics engine.
// ----------------------------------------------------------------------------
module fse_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy low after accepted beat");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe) else $error("result beat missing");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result beat without command");

endmodule

bind per_flow_statistics_engine fse_checker u_fse_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
